// File: sv/tiered_token_bucket_limiter_assert.svh
// ----------------------------------------------------------------------------
// tiered token bucket limiter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TIERED_TOKEN_BUCKET_LIMITER_ASSERT_SVH
`define TIERED_TOKEN_BUCKET_LIMITER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define TTBL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TTBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ttbl_pkg.sv
// ----------------------------------------------------------------------------
// ttbl_pkg
// types, codes and constants of the tiered token bucket limiter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttbl_pkg;

    // fraction bits of the fixed-point level, deficit and rate
    localparam int FRAC_BITS = 16;

    localparam int VAL_W   = 32;
    localparam int PRIO_W  = 8;
    localparam int RSV_W   = 8;
    localparam int CFG_IDX_W = 3;

    // reservation sum of two 8-bit counts
    localparam int RSV_SUM_W = RSV_W + 1;
    // comparison width for one token plus reservations, never overflows
    localparam int NEED_W = RSV_SUM_W + FRAC_BITS + 1;
    localparam int CMP_W  = (NEED_W > VAL_W + 1) ? NEED_W : VAL_W + 1;

    localparam logic [VAL_W-1:0] ONE_TOKEN = VAL_W'(1) << FRAC_BITS;

    localparam logic [VAL_W-1:0] RATE_RESET = 32'd655;
    localparam logic [VAL_W-1:0] CAP_RESET  = 32'd983040;
    localparam logic [RSV_W-1:0] RSV_TXN_RESET  = 8'd1;
    localparam logic [RSV_W-1:0] RSV_BACK_RESET = 8'd0;
    localparam logic [PRIO_W-1:0] TXN_PRIO_RESET  = 8'd63;
    localparam logic [PRIO_W-1:0] BACK_PRIO_RESET = 8'd127;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_TAKE    = 2'd1,
        MODE_REFUND  = 2'd2,
        MODE_PENALTY = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        TIER_TXN  = 2'd0,
        TIER_BACK = 2'd1,
        TIER_BULK = 2'd2
    } tier_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE      = 3'd0,
        CFG_CAP       = 3'd1,
        CFG_RSV_TXN   = 3'd2,
        CFG_RSV_BACK  = 3'd3,
        CFG_TXN_PRIO  = 3'd4,
        CFG_BACK_PRIO = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [PRIO_W-1:0] prio;
        logic [VAL_W-1:0]  penalty_amount;
    } item_t;

    typedef struct packed {
        logic             granted;
        logic [1:0]       tier;
        logic [VAL_W-1:0] level_after;
        logic [VAL_W-1:0] deficit_after;
    } result_t;

endpackage

// File: sv/tiered_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// tiered_token_bucket_limiter
// fixed-point token bucket with three priority tiers, refill by tick words
// ----------------------------------------------------------------------------
// One word in, one word out. An accepted word sits in the input register, the
// bucket update and the result are worked out from it and the bucket state in
// a single pass, and the result word lands in the result register, which holds
// while the result side stalls. A new word is taken every cycle as long as the
// result side keeps draining; the level and deficit registers are updated as
// each result is registered, so the next word sees them. Configuration writes
// are always ready and take effect at once; write them only while no word is in
// flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tiered_token_bucket_limiter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input word channel
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  ttbl_pkg::item_t                      item,
    // result word channel
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output ttbl_pkg::result_t                    result,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ttbl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ttbl_pkg::VAL_W-1:0]           cfg_data
);

    // configuration registers
    logic [ttbl_pkg::VAL_W-1:0]  rate_reg;
    logic [ttbl_pkg::VAL_W-1:0]  cap_reg;
    logic [ttbl_pkg::RSV_W-1:0]  rsv_txn_reg;
    logic [ttbl_pkg::RSV_W-1:0]  rsv_back_reg;
    logic [ttbl_pkg::PRIO_W-1:0] txn_prio_reg;
    logic [ttbl_pkg::PRIO_W-1:0] back_prio_reg;

    // bucket state
    logic [ttbl_pkg::VAL_W-1:0]  level_reg;
    logic [ttbl_pkg::VAL_W-1:0]  level_next;
    logic [ttbl_pkg::VAL_W-1:0]  deficit_reg;
    logic [ttbl_pkg::VAL_W-1:0]  deficit_next;

    // pipeline registers
    logic                        item_vld_reg;
    ttbl_pkg::item_t             item_reg;
    logic                        res_vld_reg;
    ttbl_pkg::result_t           res_reg;
    ttbl_pkg::result_t           res_next;

    logic                        advance;
    logic                        item_take;

    // work
    logic [ttbl_pkg::VAL_W-1:0]     gain;
    logic [ttbl_pkg::VAL_W:0]       level_sum;
    logic [ttbl_pkg::VAL_W:0]       refund_sum;
    logic [ttbl_pkg::VAL_W-1:0]     rest;
    logic [ttbl_pkg::VAL_W:0]       deficit_sum;
    logic [1:0]                     tier;
    logic [ttbl_pkg::RSV_SUM_W-1:0] reserved;
    logic [ttbl_pkg::CMP_W-1:0]     need;
    logic                           grant;

    // result register moves when empty or drained this cycle
    assign advance    = !res_vld_reg || !result_stall;
    assign item_stall = item_vld_reg && !advance;
    assign item_take  = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= ttbl_pkg::RATE_RESET;
            cap_reg       <= ttbl_pkg::CAP_RESET;
            rsv_txn_reg   <= ttbl_pkg::RSV_TXN_RESET;
            rsv_back_reg  <= ttbl_pkg::RSV_BACK_RESET;
            txn_prio_reg  <= ttbl_pkg::TXN_PRIO_RESET;
            back_prio_reg <= ttbl_pkg::BACK_PRIO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ttbl_pkg::CFG_RATE:      rate_reg      <= cfg_data;
                ttbl_pkg::CFG_CAP:       cap_reg       <= cfg_data;
                ttbl_pkg::CFG_RSV_TXN:   rsv_txn_reg   <= cfg_data[ttbl_pkg::RSV_W-1:0];
                ttbl_pkg::CFG_RSV_BACK:  rsv_back_reg  <= cfg_data[ttbl_pkg::RSV_W-1:0];
                ttbl_pkg::CFG_TXN_PRIO:  txn_prio_reg  <= cfg_data[ttbl_pkg::PRIO_W-1:0];
                ttbl_pkg::CFG_BACK_PRIO: back_prio_reg <= cfg_data[ttbl_pkg::PRIO_W-1:0];
                default: ;
            endcase
        end
    end

    // tier from priority, reservations of all higher tiers
    always_comb
    begin
        if (item_reg.prio <= txn_prio_reg)
            tier = ttbl_pkg::TIER_TXN;
        else if (item_reg.prio <= back_prio_reg)
            tier = ttbl_pkg::TIER_BACK;
        else
            tier = ttbl_pkg::TIER_BULK;

        reserved = '0;
        if (tier != ttbl_pkg::TIER_TXN)
            reserved = reserved + ttbl_pkg::RSV_SUM_W'(rsv_txn_reg);
        if (tier == ttbl_pkg::TIER_BULK)
            reserved = reserved + ttbl_pkg::RSV_SUM_W'(rsv_back_reg);

        // one token plus reservation, held wide so it never wraps
        need  = ttbl_pkg::CMP_W'(ttbl_pkg::ONE_TOKEN)
              + (ttbl_pkg::CMP_W'(reserved) << ttbl_pkg::FRAC_BITS);
        grant = ttbl_pkg::CMP_W'(level_reg) >= need;
    end

    // bucket update for the word in the input register
    always_comb
    begin
        level_next   = level_reg;
        deficit_next = deficit_reg;
        res_next.granted = 1'b0;
        res_next.tier    = ttbl_pkg::TIER_TXN;

        // tick: gain pays the deficit first
        if (rate_reg >= deficit_reg)
            gain = rate_reg - deficit_reg;
        else
            gain = '0;
        level_sum  = {1'b0, level_reg} + {1'b0, gain};
        refund_sum = {1'b0, level_reg} + {1'b0, ttbl_pkg::ONE_TOKEN};

        // penalty: unmet part goes to deficit
        rest        = item_reg.penalty_amount - level_reg;
        deficit_sum = {1'b0, deficit_reg} + {1'b0, rest};

        case (ttbl_pkg::mode_t'(item_reg.mode))
            ttbl_pkg::MODE_TICK:
            begin
                if (rate_reg >= deficit_reg)
                    deficit_next = '0;
                else
                    deficit_next = deficit_reg - rate_reg;
                if (level_sum > {1'b0, cap_reg})
                    level_next = cap_reg;
                else
                    level_next = level_sum[ttbl_pkg::VAL_W-1:0];
            end
            ttbl_pkg::MODE_TAKE:
            begin
                res_next.tier    = tier;
                res_next.granted = grant;
                if (grant)
                    level_next = level_reg - ttbl_pkg::ONE_TOKEN;
            end
            ttbl_pkg::MODE_REFUND:
            begin
                if (refund_sum > {1'b0, cap_reg})
                    level_next = cap_reg;
                else
                    level_next = refund_sum[ttbl_pkg::VAL_W-1:0];
            end
            ttbl_pkg::MODE_PENALTY:
            begin
                // zero amount leaves the state alone
                if (item_reg.penalty_amount != '0)
                begin
                    if (level_reg >= item_reg.penalty_amount)
                        level_next = level_reg - item_reg.penalty_amount;
                    else
                    begin
                        level_next = '0;
                        if (deficit_sum > {1'b0, cap_reg})
                            deficit_next = cap_reg;
                        else
                            deficit_next = deficit_sum[ttbl_pkg::VAL_W-1:0];
                    end
                end
            end
            default: ;
        endcase

        res_next.level_after   = level_next;
        res_next.deficit_after = deficit_next;
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            level_reg    <= ttbl_pkg::CAP_RESET;
            deficit_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                res_vld_reg <= item_vld_reg;
                if (item_vld_reg)
                begin
                    level_reg   <= level_next;
                    deficit_reg <= deficit_next;
                end
            end
            if (!item_stall)
                item_vld_reg <= item_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (item_take)
            item_reg <= item;
        if (advance && item_vld_reg)
            res_reg <= res_next;
    end

endmodule

// File: sv/ttbl_checker.sv
// ----------------------------------------------------------------------------
// ttbl_checker
// port-level checks of the tiered token bucket limiter, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tiered_token_bucket_limiter_assert.svh"

module ttbl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input ttbl_pkg::result_t result
);

    // a stalled result word holds
    `TTBL_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
                      result_valid && $stable(result), "result word changed while stalled")

    // input back-pressure comes only from a stalled full result register
    `TTBL_ASSERT_NOW(a_stall_cause, item_stall, result_valid && result_stall,
                     "input stalled without result back-pressure")

    // tier code is one of three
    `TTBL_ASSERT_NOW(a_tier_legal, result_valid, result.tier <= ttbl_pkg::TIER_BULK,
                     "illegal tier code in result")

endmodule

bind tiered_token_bucket_limiter ttbl_checker u_ttbl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
